// File: hw/rtl/ntlv_pkg.sv
package ntlv_pkg;

    // Scan phases of the TLV walker.
    typedef enum logic [2:0] {
        PH_SEEK,
        PH_LEN,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_VALUE,
        PH_FOUND,
        PH_TERM
    } scan_phase_t;

    // Byte codes that carry meaning in tag or length position.
    localparam logic [7:0] TAG_PAD  = 8'h00;
    localparam logic [7:0] TAG_NDEF = 8'h03;
    localparam logic [7:0] TAG_TERM = 8'hFE;
    localparam logic [7:0] LEN_LONG = 8'hFF;

    // Stop cause codes reported with each result.
    localparam logic [1:0] CAUSE_FOUND     = 2'd0;
    localparam logic [1:0] CAUSE_TERM      = 2'd1;
    localparam logic [1:0] CAUSE_TRUNCATED = 2'd2;
    localparam logic [1:0] CAUSE_CLEAN_END = 2'd3;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  stop_cause;
        logic [15:0] value_offset;
        logic [15:0] value_length;
    } out_beat_t;

endpackage

// File: hw/rtl/ntlv_ifs.sv
interface ntlv_in_if;
    logic               valid;
    logic               ready;
    ntlv_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ntlv_out_if;
    logic                valid;
    logic                ready;
    ntlv_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ndef_tlv_scanner_core.sv
// NDEF TLV scanner. Tag memory arrives one byte per beat on the bytes channel, with
// last_byte set on the final byte of a buffer. Each buffer yields exactly one beat on
// the result channel: either the offset and length of the first NDEF TLV (tag 0x03)
// whose value lies fully inside the buffer, or a not-found beat whose stop_cause tells
// whether a terminator was seen, the buffer ended inside a header or value, or the
// buffer ended cleanly. The block takes one byte every clock cycle; the phase and
// counter update for a byte is done in the cycle it is accepted, and the result beat
// for a buffer is written to the result register as its last byte is accepted. The only
// thing that stops the input is that single result register: bytes.ready is low while
// it holds a beat that the result side does not take in that cycle. Byte positions
// and offsets saturate at 65535, and all scan state returns to its reset values after
// each last byte, so the next byte starts a new buffer.
module ndef_tlv_scanner_core (
    input  logic       clk,
    input  logic       rst_n,
    ntlv_in_if.sink    bytes,
    ntlv_out_if.source result
);
    import ntlv_pkg::*;

    scan_phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] skip_reg, skip_next;
    logic        is_ndef_reg, is_ndef_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] held_offset_reg, held_offset_next;
    logic [15:0] held_length_reg, held_length_next;

    logic        result_valid_reg;
    out_beat_t   result_data_reg, result_data_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] len_value;
    logic [15:0] value_off;
    logic [15:0] skip_dec;
    logic        start_len;
    scan_phase_t phase_step;

    // The result register is free when empty or when its beat leaves this cycle.
    assign bytes.ready  = !result_valid_reg || result.ready;
    assign accept       = bytes.valid && bytes.ready;
    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    assign b         = bytes.data.data_byte;
    // Length as seen in the short-length or the low-byte phase.
    assign len_value = (phase_reg == PH_LEN_LO) ? {len_hi_reg, b} : {8'h00, b};
    // The value starts just after the current byte, saturating with the position.
    assign value_off = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;
    assign skip_dec  = skip_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEEK;
            pos_reg          <= '0;
            skip_reg         <= '0;
            is_ndef_reg      <= 1'b0;
            len_hi_reg       <= '0;
            held_offset_reg  <= '0;
            held_length_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                pos_reg         <= pos_next;
                skip_reg        <= skip_next;
                is_ndef_reg     <= is_ndef_next;
                len_hi_reg      <= len_hi_next;
                held_offset_reg <= held_offset_next;
                held_length_reg <= held_length_next;
            end
            if (accept && bytes.data.last_byte)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is only loaded with a last byte.
    always_ff @(posedge clk)
    begin
        if (accept && bytes.data.last_byte)
        begin
            result_data_reg <= result_data_next;
        end
    end

    always_comb
    begin
        phase_step       = phase_reg;
        skip_next        = skip_reg;
        is_ndef_next     = is_ndef_reg;
        len_hi_next      = len_hi_reg;
        held_offset_next = held_offset_reg;
        held_length_next = held_length_reg;
        start_len        = 1'b0;

        case (phase_reg)
            PH_SEEK:
            begin
                if (b == TAG_TERM)
                begin
                    phase_step = PH_TERM;
                end
                else if (b != TAG_PAD)
                begin
                    is_ndef_next = (b == TAG_NDEF);
                    phase_step   = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b == LEN_LONG)
                begin
                    phase_step = PH_LEN_HI;
                end
                else
                begin
                    start_len = 1'b1;
                end
            end
            PH_LEN_HI:
            begin
                len_hi_next = b;
                phase_step  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                start_len = 1'b1;
            end
            PH_VALUE:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_step = is_ndef_reg ? PH_FOUND : PH_SEEK;
                end
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase

        // A complete length either opens a value or, when zero, ends the TLV at once.
        if (start_len)
        begin
            if (len_value == 16'd0)
            begin
                if (is_ndef_reg)
                begin
                    held_offset_next = value_off;
                    held_length_next = 16'd0;
                    phase_step       = PH_FOUND;
                end
                else
                begin
                    phase_step = PH_SEEK;
                end
            end
            else
            begin
                skip_next        = len_value;
                held_offset_next = value_off;
                held_length_next = len_value;
                phase_step       = PH_VALUE;
            end
        end

        result_data_next = '0;
        case (phase_step)
            PH_FOUND:
            begin
                result_data_next.found        = 1'b1;
                result_data_next.stop_cause   = CAUSE_FOUND;
                result_data_next.value_offset = held_offset_next;
                result_data_next.value_length = held_length_next;
            end
            PH_TERM:
            begin
                result_data_next.stop_cause = CAUSE_TERM;
            end
            PH_SEEK:
            begin
                result_data_next.stop_cause = CAUSE_CLEAN_END;
            end
            default:
            begin
                result_data_next.stop_cause = CAUSE_TRUNCATED;
            end
        endcase

        phase_next = phase_step;
        pos_next   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 16'd1;

        // The last byte closes the buffer and puts the scan back to its reset state.
        if (bytes.data.last_byte)
        begin
            phase_next       = PH_SEEK;
            pos_next         = '0;
            skip_next        = '0;
            is_ndef_next     = 1'b0;
            len_hi_next      = '0;
            held_offset_next = '0;
            held_length_next = '0;
        end
    end

    // A last byte always leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes.data.last_byte |=> result_valid_reg)
    else $error("last byte accepted without a result");

    // A result that is not taken blocks further input.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result.ready |-> !bytes.ready)
    else $error("input accepted while the result register is stalled");

    // Each buffer starts from a clean scan state.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes.data.last_byte |=> phase_reg == PH_SEEK && pos_reg == 16'd0)
    else $error("scan state not cleared after last byte");

    // A not-found result carries no offset or length.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_data_reg.found
            |-> result_data_reg.value_offset == 16'd0 && result_data_reg.value_length == 16'd0
            && result_data_reg.stop_cause != CAUSE_FOUND)
    else $error("not-found result with payload");

endmodule
